// ===== sv/mmr_pkg.sv =====
// Shared constants and types for the minmod interface reconstruction block.
package mmr_pkg;

    localparam int NUM_LANES = 4;  // density, velocity_x, velocity_y, energy

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_RECON_MODE     = 2'd0;
    localparam t_cfg_idx CFG_INTERIOR_CELLS = 2'd1;
    localparam t_cfg_idx CFG_GHOST_CELLS    = 2'd2;

    localparam logic       MODE_CONSTANT = 1'b0;
    localparam logic       MODE_LINEAR   = 1'b1;

    localparam logic [10:0] INTERIOR_RESET = 11'd64;
    localparam logic [3:0]  GHOST_RESET    = 4'd2;
    localparam logic [3:0]  GHOST_MIN      = 4'd2;
    localparam logic [3:0]  GHOST_MAX      = 4'd8;

    // Control from the top level into the window cells
    typedef struct packed {
        logic load;     // shift a new cell into the chain
    } t_cell_ctrl;

endpackage

// ===== sv/mmr_cell.sv =====
// One window cell: holds a cell's four values and its difference to the older neighbor.
module mmr_cell
    import mmr_pkg::*;
#(
    parameter int VALUE_W = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_cell_ctrl                           i_ctrl,
    input  logic [NUM_LANES-1:0][VALUE_W-1:0]    i_val,
    output logic [NUM_LANES-1:0][VALUE_W-1:0]    o_val,
    output logic [NUM_LANES-1:0][VALUE_W:0]      o_diff
);

    logic [NUM_LANES-1:0][VALUE_W-1:0] r_val;
    logic [NUM_LANES-1:0][VALUE_W:0]   r_diff;
    logic [NUM_LANES-1:0][VALUE_W:0]   n_diff;

    // The value arriving from the newer side follows the value held here,
    // so its backward difference is formed against r_val.
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            n_diff[k] = {i_val[k][VALUE_W-1], i_val[k]} - {r_val[k][VALUE_W-1], r_val[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val  <= '0;
            r_diff <= '0;
        end else if (i_ctrl.load) begin
            r_val  <= i_val;
            r_diff <= n_diff;
        end
    end

    assign o_val  = r_val;
    assign o_diff = r_diff;

endmodule

// ===== sv/mmr_face.sv =====
// Face state of one cell: value plus or minus half the minmod slope, or the plain value.
module mmr_face
    import mmr_pkg::*;
#(
    parameter int VALUE_W = 32
) (
    input  logic                                 i_linear,
    input  logic                                 i_sub,       // 1: right face (value - slope/2)
    input  logic [NUM_LANES-1:0][VALUE_W-1:0]    i_val,
    input  logic [NUM_LANES-1:0][VALUE_W:0]      i_diff_own,  // cell - older neighbor
    input  logic [NUM_LANES-1:0][VALUE_W:0]      i_diff_next, // newer neighbor - cell
    output logic [NUM_LANES-1:0][VALUE_W-1:0]    o_face
);

    always_comb begin
        logic [VALUE_W:0] da;
        logic [VALUE_W:0] db;
        logic [VALUE_W:0] sel;
        logic [VALUE_W:0] hs;
        logic [VALUE_W:0] vext;
        logic [VALUE_W:0] sum;
        logic             pos_both;
        logic             neg_both;
        logic             lt;
        for (int k = 0; k < NUM_LANES; k++) begin
            da       = i_diff_own[k];
            db       = i_diff_next[k];
            pos_both = !da[VALUE_W] && (|da) && !db[VALUE_W] && (|db);
            neg_both = da[VALUE_W] && db[VALUE_W];
            lt       = $signed(da) < $signed(db);
            // smaller magnitude: min when rising, max when falling
            if (pos_both) begin
                sel = lt ? da : db;
            end else if (neg_both) begin
                sel = lt ? db : da;
            end else begin
                sel = '0;
            end
            hs   = $signed(sel) >>> 1;  // floor of half
            vext = {i_val[k][VALUE_W-1], i_val[k]};
            sum  = i_sub ? (vext - hs) : (vext + hs);
            o_face[k] = i_linear ? sum[VALUE_W-1:0] : i_val[k];
        end
    end

endmodule

// ===== sv/minmod_interface_reconstruction.sv =====
// Top level: streaming MUSCL face reconstruction with minmod limiter over one grid line.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: cell values, tuser: line_start
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: left then right faces, tlast
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// One cell per cycle sustained while the face stream is not stalled. A request
// moves through two register stages: the window chain (three cells plus
// backward differences) and the output register.
// The output register frees the input side: a new cell is taken while a
// result waits, as long as the pending face is able to move forward.
// Synchronous active-low reset clears the window to zero, the position
// counter, and restores register defaults; no clearing pass is needed.
module minmod_interface_reconstruction
    import mmr_pkg::*;
#(
    parameter int MAX_LINE_CELLS = 1024,
    parameter int VALUE_WIDTH    = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // cell stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata, low bit up: density, velocity_x, velocity_y, energy, zero fill
    input  logic [((4*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: line_start
    input  logic                        s_axis_tuser,
    // face stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata, low bit up: left_density, left_velocity_x, left_velocity_y, left_energy,
    // right_density, right_velocity_x, right_velocity_y, right_energy, zero fill
    output logic [((8*VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    output logic                        m_axis_tlast,   // last_face
    // configuration writes
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  t_cfg_idx                    i_cfg_index,
    input  t_cfg_data                   i_cfg_data
);

    localparam int IN_W      = ((4*VALUE_WIDTH+7)/8)*8;
    localparam int OUT_W     = ((8*VALUE_WIDTH+7)/8)*8;
    localparam int POS_LIMIT = MAX_LINE_CELLS + 2*8 + 1;
    localparam int POS_W     = $clog2(POS_LIMIT + 1);
    localparam int NW        = (POS_W > 11) ? POS_W : 11;

    // ---------------- configuration registers ----------------
    logic        r_mode;
    logic [10:0] r_interior;
    logic [3:0]  r_ghost;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_LINEAR;
            r_interior <= INTERIOR_RESET;
            r_ghost    <= GHOST_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RECON_MODE:     r_mode     <= i_cfg_data[0];
                CFG_INTERIOR_CELLS: r_interior <= i_cfg_data[10:0];
                CFG_GHOST_CELLS:    r_ghost    <= i_cfg_data[3:0];
                default:            ;   // unused index, write dropped
            endcase
        end
    end

    // clamped ghost and interior counts, and the position window that emits
    logic [3:0]       ghost_eff;
    logic [NW-1:0]    interior_ext;
    logic [POS_W-1:0] interior_eff;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;

    always_comb begin
        if (r_ghost < GHOST_MIN) begin
            ghost_eff = GHOST_MIN;
        end else if (r_ghost > GHOST_MAX) begin
            ghost_eff = GHOST_MAX;
        end else begin
            ghost_eff = r_ghost;
        end
        interior_ext = NW'(r_interior);
        if (interior_ext > NW'(MAX_LINE_CELLS)) begin
            interior_eff = POS_W'(MAX_LINE_CELLS);
        end else begin
            interior_eff = POS_W'(interior_ext);
        end
        first_pos = POS_W'(ghost_eff) + POS_W'(1);
        last_pos  = first_pos + interior_eff;
    end

    // ---------------- handshake and control ----------------
    logic r_pend;       // window holds a face that has not reached the output yet
    logic r_pend_last;
    logic r_ovalid;
    logic out_free;
    logic in_acc;
    logic fire_out;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = !r_pend || out_free;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign fire_out      = r_pend && out_free;

    // position counter
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] pos;
    logic             emit;
    logic             is_last;

    always_comb begin
        pos     = s_axis_tuser ? '0 : r_pos;
        emit    = (pos >= first_pos) && (pos <= last_pos);
        is_last = (pos == last_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pos       <= (pos < POS_W'(POS_LIMIT)) ? pos + POS_W'(1) : POS_W'(POS_LIMIT);
                r_pend      <= emit;
                r_pend_last <= is_last;
            end else if (fire_out) begin
                r_pend <= 1'b0;
            end
            if (fire_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------- window chain ----------------
    // cell 2 is the newest; data moves toward cell 0 on every accepted cell
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] cur;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] cell_val  [3];
    logic [NUM_LANES-1:0][VALUE_WIDTH:0]   cell_diff [3];
    t_cell_ctrl                            cell_ctrl;

    assign cur            = s_axis_tdata[4*VALUE_WIDTH-1:0];
    assign cell_ctrl.load = in_acc;

    mmr_cell #(.VALUE_W(VALUE_WIDTH)) u_cell0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (cell_ctrl),
        .i_val  (cell_val[1]),
        .o_val  (cell_val[0]),
        .o_diff (cell_diff[0])
    );

    mmr_cell #(.VALUE_W(VALUE_WIDTH)) u_cell1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (cell_ctrl),
        .i_val  (cell_val[2]),
        .o_val  (cell_val[1]),
        .o_diff (cell_diff[1])
    );

    mmr_cell #(.VALUE_W(VALUE_WIDTH)) u_cell2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (cell_ctrl),
        .i_val  (cur),
        .o_val  (cell_val[2]),
        .o_diff (cell_diff[2])
    );

    // ---------------- face states ----------------
    // left face from the older interface cell, right face from the newer one
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] left_face;
    logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] right_face;

    mmr_face #(.VALUE_W(VALUE_WIDTH)) u_face_left (
        .i_linear   (r_mode == MODE_LINEAR),
        .i_sub      (1'b0),
        .i_val      (cell_val[0]),
        .i_diff_own (cell_diff[0]),
        .i_diff_next(cell_diff[1]),
        .o_face     (left_face)
    );

    mmr_face #(.VALUE_W(VALUE_WIDTH)) u_face_right (
        .i_linear   (r_mode == MODE_LINEAR),
        .i_sub      (1'b1),
        .i_val      (cell_val[1]),
        .i_diff_own (cell_diff[1]),
        .i_diff_next(cell_diff[2]),
        .o_face     (right_face)
    );

    // ---------------- output register ----------------
    logic [OUT_W-1:0] r_odata;
    logic             r_olast;

    always_ff @(posedge i_clk) begin
        if (fire_out) begin
            r_odata <= OUT_W'({right_face, left_face});
            r_olast <= r_pend_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // zero fill bits of the input carry nothing
    logic unused_fill;
    assign unused_fill = ^s_axis_tdata[IN_W-1:0];

endmodule

// ===== sim/minmod_interface_reconstruction_tb.sv =====
// Self-checking testbench for the minmod interface reconstruction block.
`timescale 1ns / 1ps

module minmod_interface_reconstruction_tb;
    import mmr_pkg::*;

    localparam int MAX_LINE_CELLS = 1024;
    localparam int VALUE_WIDTH    = 32;
    // position counter saturates here, past the longest possible line
    localparam int POS_LIMIT      = MAX_LINE_CELLS + 2 * int'(GHOST_MAX) + 1;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int SETTLE_CYCLES  = 4;     // two register stages plus margin
    localparam int TAIL_CYCLES    = 10;
    localparam int MAX_REPORTS    = 200;   // keep the log readable on a badly broken block
    localparam int PHASE_ITEMS    = 120;
    localparam int PHASE_SETTINGS = 2;
    localparam t_cfg_idx CFG_UNUSED_IDX = 2'd3;

    // idle / stall percentages per phase, phase 0 in the low byte
    localparam logic [3:0][7:0] SRC_IDLE  = {8'd33, 8'd0, 8'd74, 8'd0};
    localparam logic [3:0][7:0] DST_STALL = {8'd33, 8'd74, 8'd0, 8'd0};

    localparam logic [31:0] VMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VMIN = 32'h8000_0000;

    // lane 0 (density) in the low bits, as on tdata
    typedef logic [NUM_LANES-1:0][VALUE_WIDTH-1:0] t_cell;

    typedef struct packed {
        logic  last;
        t_cell right;
        t_cell left;
    } t_face;

    typedef enum logic [1:0] {
        EXP_PREDICT,   // expectation comes from the face predictor
        EXP_NONE,      // no face expected
        EXP_FACE       // face typed into the row
    } t_exp_kind;

    typedef struct {
        bit        is_cfg;
        t_cfg_idx  idx;
        t_cfg_data data;
        logic      ls;
        t_cell     values;
        t_exp_kind chk;
        t_face     face;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [4*VALUE_WIDTH-1:0] s_axis_tdata;   // density, velocity_x, velocity_y, energy
    logic                 s_axis_tuser;       // line_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [8*VALUE_WIDTH-1:0] m_axis_tdata;   // left x4 lanes, then right x4 lanes
    logic                 m_axis_tlast;       // last_face
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    t_cfg_idx             i_cfg_index;
    t_cfg_data            i_cfg_data;

    minmod_interface_reconstruction #(
        .MAX_LINE_CELLS (MAX_LINE_CELLS),
        .VALUE_WIDTH    (VALUE_WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // ---------------------------------------------------------------
    // Face predictor state: register mirror, three-cell window, position
    // ---------------------------------------------------------------
    logic        rc_mode;
    logic [10:0] rc_interior;
    logic [3:0]  rc_ghost;
    t_cell       win [3];          // oldest first
    int unsigned rc_pos;

    t_face face_q [$];             // faces still owed by the block
    t_row  dir_tab [$];
    int    err_count;
    int    cycle_count;
    int    src_idle_pct;
    int    dst_stall_pct;
    string lane_name [NUM_LANES] = '{"density", "velocity_x", "velocity_y", "energy"};

    function automatic int unsigned eff_ghost();
        if (rc_ghost < GHOST_MIN) return GHOST_MIN;
        if (rc_ghost > GHOST_MAX) return GHOST_MAX;
        return rc_ghost;
    endfunction

    function automatic int unsigned eff_interior();
        return (rc_interior > MAX_LINE_CELLS) ? MAX_LINE_CELLS : rc_interior;
    endfunction

    // floor(minmod(c - l, r - c) / 2)
    function automatic longint half_slope(longint l, longint c, longint r);
        longint m;
        m = 0;
        if (l < c && c < r)
            m = (c - l < r - c) ? c - l : r - c;
        else if (c < l && r < c)
            m = (l - c < c - r) ? c - l : r - c;   // negative, smaller magnitude
        return m >>> 1;
    endfunction

    function automatic void predict_face(input logic ls, input t_cell c,
                                         output bit hit, output t_face f);
        int unsigned pos, g, n;
        longint lo, mid, hi, nx;
        f   = '0;
        pos = ls ? 0 : rc_pos;
        g   = eff_ghost();
        n   = eff_interior();
        hit = (pos >= g + 1) && (pos - g - 1 <= n);
        if (hit) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                lo  = $signed(win[0][k]);
                mid = $signed(win[1][k]);
                hi  = $signed(win[2][k]);
                nx  = $signed(c[k]);
                if (rc_mode == MODE_LINEAR) begin
                    f.left[k]  = mid + half_slope(lo, mid, hi);
                    f.right[k] = hi - half_slope(mid, hi, nx);
                end else begin
                    f.left[k]  = win[1][k];
                    f.right[k] = win[2][k];
                end
            end
            f.last = (pos - g - 1 == n);
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = c;
        rc_pos = (pos < POS_LIMIT) ? pos + 1 : POS_LIMIT;
    endfunction

    function automatic void mirror_reg(t_cfg_idx idx, t_cfg_data data);
        case (idx)
            CFG_RECON_MODE:     rc_mode     = data[0];
            CFG_INTERIOR_CELLS: rc_interior = data;
            CFG_GHOST_CELLS:    rc_ghost    = data[3:0];
            default: ;          // unknown index is dropped
        endcase
    endfunction

    function automatic void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $error("%s: expected %h, got %h", field, want, got);
    endfunction

    // ---------------------------------------------------------------
    // Directed table helpers
    // ---------------------------------------------------------------
    function automatic t_row cell_row(logic ls, logic [31:0] d, logic [31:0] vx,
                                      logic [31:0] vy, logic [31:0] e,
                                      t_exp_kind chk, t_face face);
        t_row r;
        r.is_cfg    = 1'b0;
        r.idx       = CFG_RECON_MODE;
        r.data      = '0;
        r.ls        = ls;
        r.values[0] = d;
        r.values[1] = vx;
        r.values[2] = vy;
        r.values[3] = e;
        r.chk       = chk;
        r.face      = face;
        return r;
    endfunction

    function automatic t_row cfg_row(t_cfg_idx idx, t_cfg_data data);
        t_row r;
        r        = cell_row(1'b0, '0, '0, '0, '0, EXP_NONE, '0);
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_face face_all(logic [31:0] l, logic [31:0] r, logic last);
        t_face f;
        f.left  = {NUM_LANES{l}};
        f.right = {NUM_LANES{r}};
        f.last  = last;
        return f;
    endfunction

    // ---------------------------------------------------------------
    // Clock, cycle limit, receiver
    // ---------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // downstream stall pattern, changed on the falling edge only
    always @(negedge i_clk)
        m_axis_tready = ($urandom_range(0, 99) >= dst_stall_pct);

    // every accepted face is checked against the oldest expectation
    always @(posedge i_clk) begin : face_check
        t_face want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (face_q.size() == 0) begin
                err_count++;
                $error("face request with none expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
            end else begin
                want = face_q.pop_front();
                for (int k = 0; k < NUM_LANES; k++) begin
                    if (m_axis_tdata[k*VALUE_WIDTH +: VALUE_WIDTH] !== want.left[k])
                        report_mismatch({"left_", lane_name[k]}, want.left[k],
                                        m_axis_tdata[k*VALUE_WIDTH +: VALUE_WIDTH]);
                    if (m_axis_tdata[(NUM_LANES+k)*VALUE_WIDTH +: VALUE_WIDTH] !== want.right[k])
                        report_mismatch({"right_", lane_name[k]}, want.right[k],
                                        m_axis_tdata[(NUM_LANES+k)*VALUE_WIDTH +: VALUE_WIDTH]);
                end
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_face", want.last, m_axis_tlast);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender side. Every task starts and ends on a falling edge.
    // ---------------------------------------------------------------
    task automatic send_cell(input logic ls, input t_cell c, input t_exp_kind chk,
                             input t_face typed);
        bit    hit;
        t_face f;
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = ls;
        s_axis_tdata  = c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_face(ls, c, hit, f);
        case (chk)
            EXP_PREDICT: if (hit) face_q.push_back(f);
            EXP_FACE:    face_q.push_back(typed);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // hold the cell stream until every owed face has come out
    task automatic wait_faces_drained();
        s_axis_tvalid = 1'b0;
        while (face_q.size() != 0) @(negedge i_clk);
    endtask

    // block idle: nothing owed and any face-less cell out of the pipe
    task automatic settle_block();
        wait_faces_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mirror_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // cell values: mostly ramps so the limiter sees monotone stretches,
    // with flats, reversals, extremes and full-range noise mixed in
    function automatic logic [31:0] next_value(logic [31:0] prev, int trend);
        case ($urandom_range(0, 19))
            0:       return $urandom();
            1: begin
                case ($urandom_range(0, 3))
                    0:       return VMAX;
                    1:       return VMIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            2, 3:    return prev;
            4:       return prev - trend * int'($urandom_range(0, 300));
            5:       return prev + trend * int'($urandom_range(0, 1 << 20));
            default: return prev + trend * int'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic send_noise(input int cnt);
        t_cell c;
        for (int k = 0; k < cnt; k++) begin
            for (int j = 0; j < NUM_LANES; j++) c[j] = $urandom();
            send_cell(1'b0, c, EXP_PREDICT, '0);
        end
    endtask

    // one grid line: mostly well formed, some cut short, overrun,
    // or broken by a stray line_start
    task automatic send_line(input bit first, output int sent);
        int    len, count, stray, pause_at;
        int    trend [NUM_LANES];
        t_cell c;
        len   = 2 * eff_ghost() + eff_interior();
        count = len;
        stray = -1;
        case ($urandom_range(0, 9))
            7:       count = $urandom_range(1, len);
            8:       count = len + $urandom_range(1, 8);
            9:       stray = $urandom_range(1, len - 1);
            default: ;
        endcase
        pause_at = (first || $urandom_range(0, 3) == 0) ? $urandom_range(0, count - 1) : -1;
        for (int j = 0; j < NUM_LANES; j++) begin
            c[j]     = ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 4096) - 2048;
            trend[j] = ($urandom_range(0, 1) == 0) ? 1 : -1;
        end
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) wait_faces_drained();
            if (k > 0)
                for (int j = 0; j < NUM_LANES; j++) c[j] = next_value(c[j], trend[j]);
            send_cell(k == 0 || k == stray, c, EXP_PREDICT, '0);
        end
        sent = count;
    endtask

    task automatic build_directed();
        // after reset: linear, 64 interior, 2 ghost; no line_start at all,
        // positions count from reset
        dir_tab.push_back(cell_row(1'b0, 0, 0, 0, 0, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, VMAX, VMAX, VMAX, VMAX, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, VMIN, VMIN, VMIN, VMIN, EXP_NONE, '0));
        // zero/max/min window puts an extremum in each face: limiter gives 0
        dir_tab.push_back(cell_row(1'b0, 0, 0, 0, 0, EXP_FACE, face_all(VMAX, VMIN, 1'b0)));
        dir_tab.push_back(cell_row(1'b0, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFE, 32'h8000_0001,
                                   EXP_PREDICT, '0));
        // new line with rising and falling ramps, odd steps exercise floor rounding
        dir_tab.push_back(cell_row(1'b1, 100, -100, 3, -3, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, 110, -107, 10, -10, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, 125, -120, 10, -17, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, 130, -131, 25, -31, EXP_PREDICT, '0));
        // constant mode via data with upper bits set, zero interior cells,
        // ghost count below the minimum, and a write to an unused index
        dir_tab.push_back(cfg_row(CFG_INTERIOR_CELLS, 11'd0));
        dir_tab.push_back(cfg_row(CFG_RECON_MODE, 11'h7FE));
        dir_tab.push_back(cfg_row(CFG_GHOST_CELLS, 11'h7F1));
        dir_tab.push_back(cfg_row(CFG_UNUSED_IDX, 11'h7FF));
        dir_tab.push_back(cell_row(1'b1, 1, 1, 1, 1, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, 2, 2, 2, 2, EXP_NONE, '0));
        dir_tab.push_back(cell_row(1'b0, 3, 3, 3, 3, EXP_NONE, '0));
        // the only interface is also the last face
        dir_tab.push_back(cell_row(1'b0, 4, 4, 4, 4, EXP_FACE, face_all(2, 3, 1'b1)));
        // past the end of the line: nothing comes out
        dir_tab.push_back(cell_row(1'b0, 5, 5, 5, 5, EXP_NONE, '0));
        // ghost count above the maximum, back to linear, one interior cell
        dir_tab.push_back(cfg_row(CFG_GHOST_CELLS, 11'd15));
        dir_tab.push_back(cfg_row(CFG_RECON_MODE, 11'd1));
        dir_tab.push_back(cfg_row(CFG_INTERIOR_CELLS, 11'd1));
        for (int k = 0; k < 11; k++)
            dir_tab.push_back(cell_row(k == 0, k * k * 37 - 500, 1000 - k * 300,
                                       (k & 1) ? 7 : -7, 32'h4000_0000 + k * k * k,
                                       EXP_PREDICT, '0));
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main
        int        phase_items, settings, lines, sent;
        bit        big;
        t_cfg_data int_d, ghost_d;
        t_row      row;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b1;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_RECON_MODE;
        i_cfg_data    = '0;
        err_count     = 0;
        cycle_count   = 0;
        src_idle_pct  = SRC_IDLE[0];
        dst_stall_pct = DST_STALL[0];

        rc_mode     = MODE_LINEAR;
        rc_interior = INTERIOR_RESET;
        rc_ghost    = GHOST_RESET;
        rc_pos      = 0;
        for (int k = 0; k < 3; k++) win[k] = '0;

        build_directed();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < dir_tab.size(); r++) begin
            row = dir_tab[r];
            if (row.is_cfg) begin
                settle_block();
                write_reg(row.idx, row.data);
            end else begin
                send_cell(row.ls, row.values, row.chk, row.face);
            end
        end

        // random lines, several register settings per idle phase
        for (int p = 0; p < 4; p++) begin
            src_idle_pct  = SRC_IDLE[p];
            dst_stall_pct = DST_STALL[p];
            phase_items   = 0;
            settings      = 0;
            while (phase_items < PHASE_ITEMS || settings < PHASE_SETTINGS) begin
                settle_block();
                // one full-size line in phase 3, with both counts oversized
                big = (settings == 0) && (p == 3);
                if (big) begin
                    int_d   = 11'h7FF;
                    ghost_d = 11'd15;
                end else begin
                    int_d   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
                    ghost_d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                          : $urandom_range(0, 15);
                end
                write_reg(CFG_RECON_MODE, $urandom_range(0, 2047));
                write_reg(CFG_INTERIOR_CELLS, int_d);
                write_reg(CFG_GHOST_CELLS, ghost_d);
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_UNUSED_IDX, $urandom_range(0, 2047));
                lines = big ? 1 : $urandom_range(2, 5);
                for (int l = 0; l < lines; l++) begin
                    send_line(l == 0 && settings == 0, sent);
                    phase_items += sent;
                end
                // run past the long line until the counter saturates
                if (big) send_noise(12);
                settings++;
            end
        end

        wait_faces_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
